// File: hw/rtl/whp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
package whp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
   localparam logic [15:0] MAX_CHANNELS = 16'd8;
   localparam logic [15:0] GOOD_BITS    = 16'd16;

   localparam logic [3:0] HDR_LAST_IDX   = 4'd11;
   localparam logic [3:0] RIFF_LAST_IDX  = 4'd3;
   localparam logic [3:0] CHUNK_TAG_END  = 4'd4;
   localparam logic [3:0] CHUNK_LAST_IDX = 4'd7;
   localparam logic [3:0] FMT_LAST_IDX   = 4'd15;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_CHUNK  = 3'd1,
      PH_FMT    = 3'd2,
      PH_SKIP   = 3'd3,
      PH_DONE   = 3'd4
   } whp_phase_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_TAG   = 3'd1,
      ST_EARLY_END = 3'd2,
      ST_BAD_FMT   = 3'd3,
      ST_BAD_BITS  = 3'd4
   } whp_status_type;

   typedef struct packed {
      whp_status_type status;
      logic [15:0]    channels;
      logic [31:0]    sample_rate;
      logic [15:0]    bits_per_sample;
      logic [31:0]    data_offset;
      logic [31:0]    data_length;
   } whp_rsp_type;

endpackage

// File: hw/rtl/whp_if.sv
// Stream interfaces for the parser's byte input and result output.
interface whp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface whp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] channels;
   logic [31:0] sample_rate;
   logic [15:0] bits_per_sample;
   logic [31:0] data_offset;
   logic [31:0] data_length;

   modport source (output valid, output status, output channels, output sample_rate,
                   output bits_per_sample, output data_offset, output data_length,
                   input ready);
   modport sink (input valid, input status, input channels, input sample_rate,
                 input bits_per_sample, input data_offset, input data_length,
                 output ready);
endinterface

// File: hw/rtl/whp_parser_core.sv
// Parse state machine: consumes one byte per step, produces at most one result.
module whp_parser_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           in_byte,
   input  logic                 last_byte,
   output logic                 res_valid,
   output whp_pkg::whp_rsp_type res_data
);
   import whp_pkg::*;

   whp_phase_type phase_ff, phase_in;
   logic [3:0]    idx_ff, idx_in;
   logic [31:0]   pos_ff, pos_in;
   logic [32:0]   skip_ff, skip_in;
   logic [31:0]   tag_ff, tag_in;
   logic [31:0]   size_ff, size_in;
   logic [15:0]   chan_ff, chan_in;
   logic [31:0]   rate_ff, rate_in;
   logic [15:0]   bits_ff, bits_in;

   logic           got;
   whp_status_type st;
   logic [32:0]    body;

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      skip_in   = skip_ff;
      tag_in    = tag_ff;
      size_in   = size_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      bits_in   = bits_ff;
      got       = 1'b0;
      st        = ST_OK;
      body      = {1'b0, size_ff} + {32'd0, size_ff[0]};
      res_valid = 1'b0;
      res_data  = '0;

      if (step && phase_ff != PH_DONE) begin
         if (pos_ff != 32'hFFFF_FFFF) begin
            pos_in = pos_ff + 32'd1;
         end
         case (phase_ff)
            PH_HEADER: begin
               tag_in = {tag_ff[23:0], in_byte};
               if (idx_ff == RIFF_LAST_IDX) begin
                  size_in = {31'd0, tag_in != TAG_RIFF};
               end
               if (idx_ff >= HDR_LAST_IDX) begin
                  idx_in = '0;
                  if (size_in != 32'd0 || tag_in != TAG_WAVE) begin
                     got = 1'b1;
                     st  = ST_BAD_TAG;
                  end else begin
                     chan_in  = '0;
                     rate_in  = '0;
                     bits_in  = '0;
                     size_in  = '0;
                     phase_in = PH_CHUNK;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            PH_CHUNK: begin
               if (idx_ff < CHUNK_TAG_END) begin
                  tag_in = {tag_ff[23:0], in_byte};
               end else begin
                  size_in = {in_byte, size_ff[31:8]};
               end
               body = {1'b0, size_in} + {32'd0, size_in[0]};
               if (idx_ff >= CHUNK_LAST_IDX) begin
                  idx_in = '0;
                  if (tag_in == TAG_DATA) begin
                     got = 1'b1;
                     if (chan_ff == 16'd0 || chan_ff > MAX_CHANNELS || rate_ff == 32'd0) begin
                        st = ST_BAD_FMT;
                     end else if (bits_ff != GOOD_BITS) begin
                        st = ST_BAD_BITS;
                     end else begin
                        st = ST_OK;
                     end
                  end else if (tag_in == TAG_FMT && size_in >= FMT_MIN_SIZE) begin
                     skip_in  = body - {1'b0, FMT_MIN_SIZE};
                     phase_in = PH_FMT;
                  end else begin
                     skip_in  = body;
                     phase_in = (body != 33'd0) ? PH_SKIP : PH_CHUNK;
                  end
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            PH_FMT: begin
               case (idx_ff)
                  4'd2:    chan_in[7:0]   = in_byte;
                  4'd3:    chan_in[15:8]  = in_byte;
                  4'd4:    rate_in[7:0]   = in_byte;
                  4'd5:    rate_in[15:8]  = in_byte;
                  4'd6:    rate_in[23:16] = in_byte;
                  4'd7:    rate_in[31:24] = in_byte;
                  4'd14:   bits_in[7:0]   = in_byte;
                  4'd15:   bits_in[15:8]  = in_byte;
                  default: ;
               endcase
               if (idx_ff >= FMT_LAST_IDX) begin
                  idx_in   = '0;
                  phase_in = (skip_ff != 33'd0) ? PH_SKIP : PH_CHUNK;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
            PH_SKIP: begin
               if (skip_ff != 33'd0) begin
                  skip_in = skip_ff - 33'd1;
               end
               if (skip_in == 33'd0) begin
                  phase_in = PH_CHUNK;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase

         if (got || last_byte) begin
            res_valid                = 1'b1;
            res_data.status          = got ? st : ST_EARLY_END;
            res_data.channels        = chan_in;
            res_data.sample_rate     = rate_in;
            res_data.bits_per_sample = bits_in;
            if (got && st == ST_OK) begin
               res_data.data_offset = pos_in;
               res_data.data_length = size_in;
            end
         end
         if (got) begin
            phase_in = PH_DONE;
         end
      end

      // end mark returns everything to the reset state
      if (step && last_byte) begin
         phase_in = PH_HEADER;
         idx_in   = '0;
         pos_in   = '0;
         skip_in  = '0;
         tag_in   = '0;
         size_in  = '0;
         chan_in  = '0;
         rate_in  = '0;
         bits_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         idx_ff   <= '0;
         pos_ff   <= '0;
         skip_ff  <= '0;
         tag_ff   <= '0;
         size_ff  <= '0;
         chan_ff  <= '0;
         rate_ff  <= '0;
         bits_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         tag_ff   <= tag_in;
         size_ff  <= size_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         bits_ff  <= bits_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_res_needs_step: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> step)
      else $error("result produced without a byte transaction");
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && !(step && last_byte)) |=> phase_ff == PH_DONE)
      else $error("left done phase without end mark");
   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE) |-> !res_valid)
      else $error("second result after verdict");
`endif
endmodule

// File: hw/rtl/whp_out_buf.sv
// Two-entry output buffer: result register plus skid register.
module whp_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  whp_pkg::whp_rsp_type push_data,
   input  logic                 pop_ready,
   output logic                 out_valid,
   output whp_pkg::whp_rsp_type out_data,
   output logic                 full
);
   import whp_pkg::*;

   logic        out_vld_ff, out_vld_in;
   logic        skid_vld_ff, skid_vld_in;
   whp_rsp_type out_ff, out_in;
   whp_rsp_type skid_ff, skid_in;
   logic        pop;

   assign pop       = out_vld_ff && pop_ready;
   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;
   assign full      = skid_vld_ff;

   always_comb begin
      out_vld_in  = out_vld_ff;
      skid_vld_in = skid_vld_ff;
      out_in      = out_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            out_in      = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push) begin
         if (!out_vld_ff || pop) begin
            out_in     = push_data;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = push_data;
            skid_vld_in = 1'b1;
         end
      end else if (pop) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

`ifndef NO_ASSERTIONS
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held with empty result register");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> !push)
      else $error("result pushed into full buffer");
   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_vld_ff && pop) |=> (out_vld_ff && out_ff == $past(skid_ff)))
      else $error("skid entry lost on transaction");
`endif
endmodule

// File: hw/rtl/wav_header_parser_unit.sv
// Top level of the RIFF/WAVE header parser.
//
//  channel | dir | handshake          | payload
//  req_bus | in  | valid/ready        | in_byte[7:0], last_byte
//  rsp_bus | out | valid/ready        | status, channels, sample_rate,
//          |     |                    | bits_per_sample, data_offset, data_length
//
// One byte per cycle sustained. A byte is held in the input register, then the
// parser updates its state and, on a verdict or end mark, writes a result into
// the two-entry output buffer, which presents it on rsp_bus. Input stalls only
// when both output entries are full. Synchronous reset clears the parse state
// and all valid flags.
module wav_header_parser_unit (
   input logic  clock,
   input logic  reset,
   whp_req_if.sink   req_bus,
   whp_rsp_if.source rsp_bus
);
   import whp_pkg::*;

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        advance;
   logic        step;
   logic        full;
   logic        res_valid;
   whp_rsp_type res_data;
   logic        out_valid;
   whp_rsp_type out_data;

   assign advance       = !full;
   assign step          = in_vld_ff && advance;
   assign req_bus.ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.in_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   whp_parser_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .in_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   whp_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .pop_ready (rsp_bus.ready),
      .out_valid (out_valid),
      .out_data  (out_data),
      .full      (full)
   );

   assign rsp_bus.valid           = out_valid;
   assign rsp_bus.status          = out_data.status;
   assign rsp_bus.channels        = out_data.channels;
   assign rsp_bus.sample_rate     = out_data.sample_rate;
   assign rsp_bus.bits_per_sample = out_data.bits_per_sample;
   assign rsp_bus.data_offset     = out_data.data_offset;
   assign rsp_bus.data_length     = out_data.data_length;
endmodule

// File: tb/wav_header_parser_unit_test.sv
// Self-checking testbench for the RIFF/WAVE header parser: WAV byte streams in, verdicts checked.
`timescale 1ns / 1ps

module wav_header_parser_unit_test;
   import whp_pkg::*;

   class whp_verdict_book;
      whp_phase_type phase;
      logic [4:0]    idx;
      logic [31:0]   pos;
      logic [32:0]   skip;
      logic [31:0]   tag;
      logic [31:0]   acc;
      logic [15:0]   chans;
      logic [31:0]   rate;
      logic [15:0]   bits;
      whp_rsp_type   due_verdicts[$];
      int            errors;
      int            live_bytes;
      int            verdicts_made;

      function new();
         errors = 0;
         live_bytes = 0;
         verdicts_made = 0;
         restart_parse();
      endfunction

      function void restart_parse();
         phase = PH_HEADER;
         idx = '0;
         pos = '0;
         skip = '0;
         tag = '0;
         acc = '0;
         chans = '0;
         rate = '0;
         bits = '0;
      endfunction

      function void queue_verdict(whp_status_type st, logic [31:0] len);
         whp_rsp_type v;
         v.status = st;
         v.channels = chans;
         v.sample_rate = rate;
         v.bits_per_sample = bits;
         v.data_offset = (st == ST_OK) ? pos : 32'd0;
         v.data_length = (st == ST_OK) ? len : 32'd0;
         due_verdicts.push_back(v);
         verdicts_made++;
      endfunction

      // Advances the parse state by one accepted byte transaction.
      function void take_byte(logic [7:0] b, logic lst);
         logic           got;
         whp_status_type st;
         logic [31:0]    sz;
         logic [32:0]    body;
         got = 1'b0;
         st = ST_OK;
         sz = '0;
         if (phase == PH_DONE) begin
            if (lst) restart_parse();
            return;
         end
         live_bytes++;
         if (pos != 32'hFFFF_FFFF) pos = pos + 32'd1;
         case (phase)
            PH_HEADER: begin
               tag = {tag[23:0], b};
               if (idx == RIFF_LAST_IDX) acc = (tag != TAG_RIFF) ? 32'd1 : 32'd0;
               if (idx >= HDR_LAST_IDX) begin
                  idx = '0;
                  if (acc != 0 || tag != TAG_WAVE) begin
                     got = 1'b1;
                     st = ST_BAD_TAG;
                  end else begin
                     chans = '0;
                     rate = '0;
                     bits = '0;
                     acc = '0;
                     phase = PH_CHUNK;
                  end
               end else begin
                  idx = idx + 5'd1;
               end
            end
            PH_CHUNK: begin
               if (idx < CHUNK_TAG_END) tag = {tag[23:0], b};
               else acc = {b, acc[31:8]};
               if (idx >= CHUNK_LAST_IDX) begin
                  sz = acc;
                  body = {1'b0, sz} + {32'd0, sz[0]};
                  idx = '0;
                  if (tag == TAG_DATA) begin
                     got = 1'b1;
                     if (chans == 0 || chans > MAX_CHANNELS || rate == 0) st = ST_BAD_FMT;
                     else if (bits != GOOD_BITS) st = ST_BAD_BITS;
                     else st = ST_OK;
                  end else if (tag == TAG_FMT && sz >= FMT_MIN_SIZE) begin
                     skip = body - 33'(FMT_MIN_SIZE);
                     phase = PH_FMT;
                  end else begin
                     skip = body;
                     phase = (body != 0) ? PH_SKIP : PH_CHUNK;
                  end
               end else begin
                  idx = idx + 5'd1;
               end
            end
            PH_FMT: begin
               // body offsets: channels 2..3, rate 4..7, bits 14..15
               case (idx)
                  5'd2: chans[7:0] = b;
                  5'd3: chans[15:8] = b;
                  5'd4: rate[7:0] = b;
                  5'd5: rate[15:8] = b;
                  5'd6: rate[23:16] = b;
                  5'd7: rate[31:24] = b;
                  5'd14: bits[7:0] = b;
                  5'd15: bits[15:8] = b;
                  default: ;
               endcase
               if (idx >= FMT_LAST_IDX) begin
                  idx = '0;
                  phase = (skip != 0) ? PH_SKIP : PH_CHUNK;
               end else begin
                  idx = idx + 5'd1;
               end
            end
            default: begin
               if (skip != 0) skip = skip - 33'd1;
               if (skip == 0) phase = PH_CHUNK;
            end
         endcase
         if (got) begin
            queue_verdict(st, sz);
            phase = PH_DONE;
            if (lst) restart_parse();
         end else if (lst) begin
            queue_verdict(ST_EARLY_END, 32'd0);
            restart_parse();
         end
      endfunction

      task report_miss(string msg);
         if (errors < 50) $display("[%0t] MISMATCH %s", $time, msg);
         errors++;
      endtask

      task match_verdict(whp_rsp_type got);
         whp_rsp_type want;
         if (due_verdicts.size() == 0) begin
            report_miss($sformatf("verdict with none pending: status %0d", got.status));
            return;
         end
         want = due_verdicts.pop_front();
         if (got.status != want.status)
            report_miss($sformatf("status got %0d want %0d", got.status, want.status));
         if (got.channels != want.channels)
            report_miss($sformatf("channels got %h want %h", got.channels, want.channels));
         if (got.sample_rate != want.sample_rate)
            report_miss($sformatf("sample_rate got %h want %h", got.sample_rate,
                                  want.sample_rate));
         if (got.bits_per_sample != want.bits_per_sample)
            report_miss($sformatf("bits_per_sample got %h want %h", got.bits_per_sample,
                                  want.bits_per_sample));
         if (got.data_offset != want.data_offset)
            report_miss($sformatf("data_offset got %h want %h", got.data_offset,
                                  want.data_offset));
         if (got.data_length != want.data_length)
            report_miss($sformatf("data_length got %h want %h", got.data_length,
                                  want.data_length));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic steady;

   whp_req_if req_bus();
   whp_rsp_if rsp_bus();

   wav_header_parser_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   whp_verdict_book book = new();
   logic [7:0]      file_q[$];

   always #1 clock = ~clock;

   // result side: check on accepted transactions, then pick next ready
   always @(posedge clock) begin
      whp_rsp_type seen;
      if (rsp_bus.valid && rsp_bus.ready) begin
         seen.status = whp_status_type'(rsp_bus.status);
         seen.channels = rsp_bus.channels;
         seen.sample_rate = rsp_bus.sample_rate;
         seen.bits_per_sample = rsp_bus.bits_per_sample;
         seen.data_offset = rsp_bus.data_offset;
         seen.data_length = rsp_bus.data_length;
         book.match_verdict(seen);
      end
      rsp_bus.ready <= steady || ($urandom_range(99) >= 12);
   end

   function automatic void put_tag(logic [31:0] t);
      file_q.push_back(t[31:24]);
      file_q.push_back(t[23:16]);
      file_q.push_back(t[15:8]);
      file_q.push_back(t[7:0]);
   endfunction

   function automatic void put_le16(logic [15:0] v);
      file_q.push_back(v[7:0]);
      file_q.push_back(v[15:8]);
   endfunction

   function automatic void put_le32(logic [31:0] v);
      put_le16(v[15:0]);
      put_le16(v[31:16]);
   endfunction

   function automatic void put_file_head();
      put_tag(TAG_RIFF);
      put_le32($urandom);
      put_tag(TAG_WAVE);
   endfunction

   // Chunk with opaque body plus pad byte on odd size.
   function automatic void put_chunk(logic [31:0] t, int unsigned size);
      put_tag(t);
      put_le32(size);
      repeat (size + (size % 2)) file_q.push_back(8'($urandom));
   endfunction

   function automatic void put_fmt(int unsigned size, logic [15:0] ch, logic [31:0] hz,
                                   logic [15:0] nbits);
      put_tag(TAG_FMT);
      put_le32(size);
      put_le16(16'h0001);
      put_le16(ch);
      put_le32(hz);
      put_le32($urandom);
      put_le16(16'($urandom));
      put_le16(nbits);
      repeat (size - 16 + (size % 2)) file_q.push_back(8'($urandom));
   endfunction

   function automatic void put_data(logic [31:0] len, int unsigned payload);
      put_tag(TAG_DATA);
      put_le32(len);
      repeat (payload) file_q.push_back(8'($urandom));
   endfunction

   task automatic send_byte(logic [7:0] b, logic lst);
      if (!steady) begin
         while ($urandom_range(99) < 12) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.last_byte <= lst;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      book.take_byte(b, lst);
   endtask

   // Sends the first count bytes of the built file (all when count is 0), end mark on the final one.
   task automatic send_file(int count);
      int n;
      n = (count == 0 || count > file_q.size()) ? file_q.size() : count;
      for (int i = 0; i < n; i++) send_byte(file_q[i], i == n - 1);
      file_q.delete();
   endtask

   task automatic drain_verdicts();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (book.due_verdicts.size() != 0) @(posedge clock);
   endtask

   task automatic directed_files();
      // clean file, data header byte also carries the end mark
      put_file_head();
      put_fmt(16, 16'd2, 32'd44100, 16'd16);
      put_data(32'hFFFF_FFFF, 0);
      send_file(0);
      // bad RIFF tag, then ignored bytes until the end mark
      put_tag(32'h5249_4658);
      put_le32(32'h0);
      put_tag(TAG_WAVE);
      file_q.push_back(8'hFF);
      file_q.push_back(8'h00);
      send_file(0);
      // bad WAVE tag on the last header byte with end mark
      put_tag(TAG_RIFF);
      put_le32(32'hFFFF_FFFF);
      put_tag(32'h5741_5646);
      send_file(0);
      // no fmt chunk, odd junk chunk with pad
      put_file_head();
      put_chunk(32'h4C49_5354, 3);
      put_data(32'd0, 2);
      send_file(0);
      // channels out of range, zero rate, long fmt
      put_file_head();
      put_fmt(18, 16'hFFFF, 32'd0, 16'hFFFF);
      put_data(32'd100, 1);
      send_file(0);
      // unsupported bits
      put_file_head();
      put_fmt(16, 16'd1, 32'd1, 16'd8);
      put_data(32'd7, 1);
      send_file(0);
      // second fmt overwrites the first
      put_file_head();
      put_fmt(16, 16'd1, 32'd8000, 16'd8);
      put_fmt(17, 16'd8, 32'hFFFF_FFFF, 16'd16);
      put_data(32'd64, 3);
      send_file(0);
      // short fmt is skipped, leaving no format
      put_file_head();
      put_chunk(TAG_FMT, 14);
      put_data(32'd16, 1);
      send_file(0);
      // stream ends inside fmt body after the rate bytes
      put_file_head();
      put_fmt(16, 16'd2, 32'd48000, 16'd16);
      send_file(28);
      // huge chunk cut short
      put_file_head();
      put_chunk(32'h4A55_4E4B, 0);
      file_q[16] = 8'hFF;
      file_q[17] = 8'hFF;
      file_q[18] = 8'hFF;
      file_q[19] = 8'hFF;
      repeat (5) file_q.push_back(8'($urandom));
      send_file(0);
      // lone byte with end mark
      file_q.push_back(8'hFF);
      send_file(0);
   endtask

   task automatic random_file();
      int          kind;
      int unsigned cut;
      logic [15:0] ch;
      logic [31:0] hz;
      logic [15:0] nbits;
      logic [31:0] len;
      kind = $urandom_range(99);
      cut = 0;
      if (kind < 10) begin
         repeat ($urandom_range(1, 30)) file_q.push_back(8'($urandom));
      end else begin
         put_file_head();
         repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(2))
               0: put_chunk($urandom, $urandom_range(0, 9));
               1: put_chunk(TAG_FMT, $urandom_range(0, 15));
               default: put_fmt($urandom_range(16, 24), 16'($urandom), $urandom, 16'($urandom));
            endcase
         end
         if ($urandom_range(99) < 85) begin
            ch = ($urandom_range(99) < 75) ? 16'($urandom_range(1, 8))
                                             : 16'($urandom_range(1) ? 9 : $urandom);
            hz = ($urandom_range(99) < 85) ? $urandom : 32'd0;
            nbits = ($urandom_range(99) < 75) ? 16'd16 : 16'($urandom);
            put_fmt(($urandom_range(99) < 70) ? 16 : $urandom_range(16, 24), ch, hz, nbits);
         end
         case ($urandom_range(9))
            0: len = 32'd0;
            1: len = $urandom;
            default: len = $urandom_range(0, 4096);
         endcase
         put_data(len, $urandom_range(0, 4));
         kind = $urandom_range(99);
         if (kind < 10) cut = $urandom_range(1, file_q.size());
         else if (kind < 18) file_q[$urandom_range(0, file_q.size() - 1)] ^= 8'(1 << $urandom_range(7));
      end
      send_file(cut);
   endtask

   initial begin
      int n_files;
      steady <= 1'b0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.in_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_files();
      n_files = 0;
      while (book.live_bytes < 900) begin
         steady <= (n_files >= 3 && n_files < 7);
         if (n_files == 1) drain_verdicts();
         random_file();
         n_files++;
      end
      steady <= 1'b0;
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (book.due_verdicts.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (book.errors == 0 && book.due_verdicts.size() == 0) begin
         $display("wav_header_parser_unit regression: pass");
      end else begin
         $display("wav_header_parser_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("wav_header_parser_unit regression: fail");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/whp_pkg.sv
hw/rtl/whp_if.sv
hw/rtl/whp_parser_core.sv
hw/rtl/whp_out_buf.sv
hw/rtl/wav_header_parser_unit.sv
tb/wav_header_parser_unit_test.sv
